/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FSBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block planner check failed");
// next-cycle implication
`define FSBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block planner check failed");
`else
`define FSBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FSBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/fsbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbp_pkg
// Shared constants and types of the file split block planner.
// ----------------------------------------------------------------------------
package fsbp_pkg;

    localparam int MAX_CHUNKS   = 32;
    localparam int MAX_SEGMENTS = 32;
    localparam int MAX_BLOCKS   = 65536;

    localparam int SIZE_W  = 40;  // file size / offsets
    localparam int BS_W    = 31;  // block size
    localparam int ID_W    = 16;
    localparam int SEG_W   = 6;   // segment count
    localparam int SID_W   = 5;   // segment id
    localparam int CHUNK_W = $clog2(MAX_CHUNKS + 1);
    localparam int IDX_W   = $clog2(MAX_BLOCKS + 1);
    localparam int DIV_STEPS = SIZE_W;

    // register indexes of the config port
    localparam logic [1:0] CFG_BLOCK_SIZE    = 2'd0;
    localparam logic [1:0] CFG_SEGMENT_COUNT = 2'd1;
    localparam logic [1:0] CFG_SEGMENT_ID    = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] dividend;
        logic [BS_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic [SIZE_W-1:0] quot;
        logic [BS_W-1:0]   rem;
    } t_div_rsp;

endpackage

/* hdl/fsbp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbp_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsbp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  fsbp_pkg::t_div_req  i_req,
    output logic                o_done,
    output fsbp_pkg::t_div_rsp  o_rsp
);
    import fsbp_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [BS_W-1:0]   r_rem;
    logic [SIZE_W-1:0] r_quo;
    logic [BS_W-1:0]   r_dvsr;

    logic [BS_W:0]     n_shift;
    logic [BS_W:0]     n_diff;
    logic              n_ge;
    logic [BS_W-1:0]   n_rem;
    logic [SIZE_W-1:0] n_quo;

    // remainder stays below the divisor, so the shifted value fits BS_W+1 bits
    always_comb begin
        n_shift = {r_rem, r_quo[SIZE_W-1]};
        n_diff  = n_shift - {1'b0, r_dvsr};
        n_ge    = (n_shift >= {1'b0, r_dvsr});
        n_rem   = n_ge ? n_diff[BS_W-1:0] : n_shift[BS_W-1:0];
        n_quo   = {r_quo[SIZE_W-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvsr <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rsp  = '{quot: r_quo, rem: r_rem};

endmodule

/* hdl/file_split_block_planner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_split_block_planner
// Cuts a list of files into block descriptors and pads the table per segment.
// ----------------------------------------------------------------------------
// One file request is taken at a time; o_s_tready is high only while the
// planner is idle. Each file first runs a 40-step division of its size by the
// block size on the shared divider, then one planning step. A plain file then
// emits one descriptor per block (up to 32) at one per cycle while the output
// is not stalled, and holds the input until its last descriptor is registered.
// A file marked tlast also runs the divider twice more on the block count
// (padding remainder, then blocks per segment) plus three set-up steps before
// its first descriptor; its blocks and padding then follow at one per cycle
// while the output is not stalled. Descriptors leave through an output
// register, so a new file can be taken while the final descriptor of the
// previous one still waits. Config writes land at once and must be done
// while the planner is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module file_split_block_planner (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config port
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_index,
    input  logic [30:0]   i_cfg_wdata,
    // file requests
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [55:0]   i_s_tdata,   // file_id[15:0], file_size[55:16]
    input  logic          i_s_tlast,   // last_file
    // block descriptors
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // block_index[15:0], owner_file[31:16], file_length[71:32],
    // offset_start[111:72], offset_end[151:112], range_begin[167:152],
    // range_end[184:168], zero[191:185]
    output logic [191:0]  o_m_tdata,
    output logic [2:0]    o_m_tuser,   // block_present[0], too_big[1], range_valid[2]
    output logic          o_m_tlast    // last_of_run
);
    import fsbp_pkg::*;

    localparam int PROD_W = SID_W + IDX_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_SIZE,
        ST_PLAN,
        ST_DIV_PAD,
        ST_PAD_CALC,
        ST_DIV_PER,
        ST_RANGE_MUL,
        ST_RANGE_END,
        ST_EMIT_ERR,
        ST_EMIT_BLK,
        ST_EMIT_PAD
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]        block_index;
        logic [ID_W-1:0]        owner_file;
        logic [SIZE_W-1:0]      file_length;
        logic [SIZE_W-1:0]      offset_start;
        logic [SIZE_W-1:0]      offset_end;
        logic                   present;
        logic                   too_big;
        logic                   range_valid;
        logic [ID_W-1:0]        range_begin;
        logic signed [IDX_W-1:0] range_end;
        logic                   last;
    } t_result;

    // config registers
    logic [BS_W-1:0]    r_block_size;
    logic [SEG_W-1:0]   r_seg_count;
    logic [SID_W-1:0]   r_seg_id;

    // sequencer state
    t_state             r_state;
    logic [IDX_W-1:0]   r_next_idx;
    logic               r_div_go;
    t_div_req           r_div_req;
    logic [ID_W-1:0]    r_id;
    logic [SIZE_W-1:0]  r_size;
    logic               r_last;
    logic [BS_W-1:0]    r_bs;
    logic [SEG_W-1:0]   r_sc;
    logic [CHUNK_W-1:0] r_n;
    logic               r_err;
    logic [IDX_W-1:0]   r_tail;
    logic [CHUNK_W-1:0] r_blk;
    logic [SIZE_W-1:0]  r_start;
    logic [SEG_W-1:0]   r_pad;
    logic [IDX_W-1:0]   r_per;
    logic [PROD_W-1:0]  r_prod;
    logic [ID_W-1:0]    r_range_begin;
    logic [IDX_W-1:0]   r_range_end;

    // output register
    logic               r_m_valid;
    t_result            r_m;

    logic               div_done;
    t_div_rsp           div_rsp;

    fsbp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_req   (r_div_req),
        .o_done  (div_done),
        .o_rsp   (div_rsp)
    );

    // effective config: zero block size acts as 1, segment count clamped
    logic [BS_W-1:0]  bs_eff;
    logic [SEG_W-1:0] sc_eff;
    always_comb begin
        bs_eff = (r_block_size == '0) ? BS_W'(1) : r_block_size;
        if (r_seg_count == '0)
            sc_eff = SEG_W'(1);
        else if (r_seg_count > SEG_W'(MAX_SEGMENTS))
            sc_eff = SEG_W'(MAX_SEGMENTS);
        else
            sc_eff = r_seg_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BS_W'(16777216);
            r_seg_count  <= SEG_W'(1);
            r_seg_id     <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BLOCK_SIZE:    r_block_size <= i_cfg_wdata;
                CFG_SEGMENT_COUNT: r_seg_count  <= i_cfg_wdata[SEG_W-1:0];
                CFG_SEGMENT_ID:    r_seg_id     <= i_cfg_wdata[SID_W-1:0];
                default:           ;
            endcase
        end
    end

    // planning: block count from quotient and tail, then limit checks
    logic                 pl_small;
    logic                 pl_tail_gt;
    logic                 pl_big;
    logic [CHUNK_W-1:0]   pl_n;
    logic [IDX_W:0]       pl_sum;
    logic                 pl_err;
    logic [IDX_W-1:0]     pl_tail;
    always_comb begin
        pl_small   = (r_size <= {{(SIZE_W-BS_W){1'b0}}, r_bs});
        pl_tail_gt = (div_rsp.rem > {1'b0, r_bs[BS_W-1:1]});
        pl_big     = !pl_small &&
                     ((|div_rsp.quot[SIZE_W-1:CHUNK_W]) ||
                      (div_rsp.quot[CHUNK_W-1:0] > CHUNK_W'(MAX_CHUNKS)) ||
                      ((div_rsp.quot[CHUNK_W-1:0] == CHUNK_W'(MAX_CHUNKS)) && pl_tail_gt));
        pl_n       = pl_small ? CHUNK_W'(1)
                              : div_rsp.quot[CHUNK_W-1:0] + CHUNK_W'(pl_tail_gt);
        pl_sum     = {1'b0, r_next_idx} + (IDX_W+1)'(pl_n);
        pl_err     = pl_big || (pl_sum > (IDX_W+1)'(MAX_BLOCKS));
        pl_tail    = pl_err ? r_next_idx : pl_sum[IDX_W-1:0];
    end

    // padding count, capped by the room left in the table
    logic [SEG_W-1:0] pd_rem;
    logic [SEG_W-1:0] pd_raw;
    logic [IDX_W-1:0] pd_room;
    logic [SEG_W-1:0] pd_cnt;
    logic [IDX_W-1:0] pd_total;
    always_comb begin
        pd_rem  = div_rsp.rem[SEG_W-1:0];
        pd_raw  = r_sc - pd_rem;
        pd_room = IDX_W'(MAX_BLOCKS) - r_tail;
        if (pd_rem == '0)
            pd_cnt = '0;
        else if (IDX_W'(pd_raw) > pd_room)
            pd_cnt = pd_room[SEG_W-1:0];
        else
            pd_cnt = pd_raw;
        pd_total = r_tail + IDX_W'(pd_cnt);
    end

    // range of the selected segment
    logic              rg_ok;
    logic [PROD_W-1:0] rg_end_sum;
    always_comb begin
        rg_ok      = ({1'b0, r_seg_id} < r_sc) && (r_per != '0);
        rg_end_sum = r_prod + PROD_W'(r_per) - PROD_W'(1);
    end

    // descriptor for the current emit step
    logic              out_free;
    logic              em_blk_last;
    logic              em_final;
    logic [SIZE_W-1:0] em_next_start;
    t_result           em_res;
    always_comb begin
        out_free      = !r_m_valid || i_m_tready;
        em_next_start = r_start + SIZE_W'(r_bs);
        em_blk_last   = (r_blk == r_n - CHUNK_W'(1));
        em_res        = '0;
        em_final      = 1'b0;
        case (r_state)
            ST_EMIT_ERR: begin
                em_res.owner_file  = r_id;
                em_res.file_length = r_size;
                em_res.too_big     = 1'b1;
                em_final           = (r_pad == '0);
            end
            ST_EMIT_BLK: begin
                em_res.block_index  = r_next_idx[ID_W-1:0];
                em_res.owner_file   = r_id;
                em_res.file_length  = r_size;
                em_res.offset_start = r_start;
                em_res.offset_end   = em_blk_last ? r_size : em_next_start;
                em_res.present      = 1'b1;
                em_final            = em_blk_last && (r_pad == '0);
            end
            ST_EMIT_PAD: begin
                em_res.block_index = r_next_idx[ID_W-1:0];
                em_final           = (r_pad == SEG_W'(1));
            end
            default: ;
        endcase
        em_res.last = em_final;
        if (em_final && r_last) begin
            em_res.range_valid = 1'b1;
            em_res.range_begin = r_range_begin;
            em_res.range_end   = r_range_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_next_idx <= '0;
            r_div_go   <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (i_m_tready)
                r_m_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_id      <= i_s_tdata[ID_W-1:0];
                        r_size    <= i_s_tdata[ID_W+SIZE_W-1:ID_W];
                        r_last    <= i_s_tlast;
                        r_bs      <= bs_eff;
                        r_sc      <= sc_eff;
                        r_div_req <= '{dividend: i_s_tdata[ID_W+SIZE_W-1:ID_W],
                                       divisor: bs_eff};
                        r_div_go  <= 1'b1;
                        r_state   <= ST_DIV_SIZE;
                    end
                end
                ST_DIV_SIZE: begin
                    if (div_done)
                        r_state <= ST_PLAN;
                end
                ST_PLAN: begin
                    r_n     <= pl_n;
                    r_err   <= pl_err;
                    r_tail  <= pl_tail;
                    r_blk   <= '0;
                    r_start <= '0;
                    r_pad   <= '0;
                    if (r_last) begin
                        r_div_req <= '{dividend: SIZE_W'(pl_tail), divisor: BS_W'(r_sc)};
                        r_div_go  <= 1'b1;
                        r_state   <= ST_DIV_PAD;
                    end else begin
                        r_state <= pl_err ? ST_EMIT_ERR : ST_EMIT_BLK;
                    end
                end
                ST_DIV_PAD: begin
                    if (div_done)
                        r_state <= ST_PAD_CALC;
                end
                ST_PAD_CALC: begin
                    r_pad     <= pd_cnt;
                    r_div_req <= '{dividend: SIZE_W'(pd_total), divisor: BS_W'(r_sc)};
                    r_div_go  <= 1'b1;
                    r_state   <= ST_DIV_PER;
                end
                ST_DIV_PER: begin
                    if (div_done)
                        r_state <= ST_RANGE_MUL;
                end
                ST_RANGE_MUL: begin
                    r_per   <= div_rsp.quot[IDX_W-1:0];
                    r_prod  <= PROD_W'(r_seg_id) * PROD_W'(div_rsp.quot[IDX_W-1:0]);
                    r_state <= ST_RANGE_END;
                end
                ST_RANGE_END: begin
                    r_range_begin <= rg_ok ? r_prod[ID_W-1:0] : '0;
                    r_range_end   <= rg_ok ? rg_end_sum[IDX_W-1:0] : '1;
                    r_state       <= r_err ? ST_EMIT_ERR : ST_EMIT_BLK;
                end
                ST_EMIT_ERR: begin
                    if (out_free) begin
                        r_m       <= em_res;
                        r_m_valid <= 1'b1;
                        r_state   <= em_final ? ST_IDLE : ST_EMIT_PAD;
                    end
                end
                ST_EMIT_BLK: begin
                    if (out_free) begin
                        r_m        <= em_res;
                        r_m_valid  <= 1'b1;
                        r_next_idx <= r_next_idx + IDX_W'(1);
                        r_start    <= em_next_start;
                        r_blk      <= r_blk + CHUNK_W'(1);
                        if (em_final)
                            r_state <= ST_IDLE;
                        else if (em_blk_last)
                            r_state <= ST_EMIT_PAD;
                    end
                end
                ST_EMIT_PAD: begin
                    if (out_free) begin
                        r_m        <= em_res;
                        r_m_valid  <= 1'b1;
                        r_next_idx <= r_next_idx + IDX_W'(1);
                        r_pad      <= r_pad - SEG_W'(1);
                        if (em_final)
                            r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // a finished list starts a fresh table
            if (out_free && em_final && r_last)
                r_next_idx <= '0;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'd0, r_m.range_end, r_m.range_begin, r_m.offset_end,
                         r_m.offset_start, r_m.file_length, r_m.owner_file,
                         r_m.block_index};
    assign o_m_tuser  = {r_m.range_valid, r_m.too_big, r_m.present};
    assign o_m_tlast  = r_m.last;

    `FSBP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `FSBP_ASSERT_IMPLY(a_range_on_last, i_clk, i_rst_n, r_m_valid && r_m.range_valid, r_m.last)
    `FSBP_ASSERT_IMPLY(a_err_no_block, i_clk, i_rst_n, r_m_valid && r_m.too_big, !r_m.present)
    `FSBP_ASSERT_IMPLY(a_idx_bound, i_clk, i_rst_n, 1'b1, r_next_idx <= IDX_W'(MAX_BLOCKS))

endmodule
